>>> sv/ersd_pkg.sv
// Package for the echo range filter: item types, controller states and
// fixed constants of the step and duty conversion. No dependencies.
`default_nettype none

package ersd_pkg;

  localparam int unsigned ECHO_W = 20;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned DUTY_W = 7;

  localparam logic [ECHO_W-1:0] MAX_ECHO_RESET = 20'd20000;

  // step = floor(mean * SPEED_NUM / STEP_DEN) + 1, capped at STEP_CAP
  localparam int unsigned SPEED_W   = 9;
  localparam int unsigned SPEED_NUM = 331;
  localparam int unsigned STEP_DEN  = 200000;
  localparam int unsigned STEP_CAP  = 9;
  localparam int unsigned DUTY_SCALE = 10;
  localparam int unsigned PROD_W = ECHO_W + SPEED_W;

  typedef struct packed {
    logic [ECHO_W-1:0] echo_us;
    logic              timed_out;
  } in_item_t;

  typedef struct packed {
    logic [ECHO_W-1:0] mean_echo_us;
    logic              none_valid;
    logic [STEP_W-1:0] range_step;
    logic [DUTY_W-1:0] duty_percent;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> sv/ersd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ersd_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/echo_range_filter_to_servo_duty.sv
// Top level of the echo range filter: window RAM, sweep accumulator, serial
// divider and step/duty conversion. Uses ersd_pkg and ersd_ram.
//
//   channel | signals                    | direction | payload
//   --------+----------------------------+-----------+----------------------
//   in      | in_valid, in_ready         | into      | in_item (in_item_t)
//   out     | out_valid, out_ready       | out of    | out_item (out_item_t)
//   cfg     | cfg_valid, cfg_ready       | into      | cfg_data (max_echo_us)
//
// Items are taken only in the idle state. The sweep reads one window entry per
// cycle through the RAM read port; the restoring divider retires one quotient
// bit per cycle.
// A timed-out item is dropped in the cycle it is taken.
// Reset clears the entry valid bits and the write slot, sets max_echo_us to 20000.
// Items are taken while a result waits; the next result holds until out_ready.
`default_nettype none

module echo_range_filter_to_servo_duty #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ersd_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ersd_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ersd_pkg::ECHO_W-1:0] cfg_data
);

  import ersd_pkg::*;

  localparam int unsigned ADDR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W  = ECHO_W + CNT_W;
  localparam int unsigned ITER_W = $clog2(SUM_W);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_LEN - 1);

  state_t state, state_next;

  logic [ECHO_W-1:0]     max_echo;
  logic [ADDR_W-1:0]     write_slot;
  logic [ADDR_W-1:0]     rd_addr;
  logic [WINDOW_LEN-1:0] entry_vld;
  logic                  rd_pend;
  logic                  rd_vld;
  logic [ECHO_W-1:0]     rd_data;
  logic [SUM_W-1:0]      sum;
  logic [CNT_W-1:0]      cnt;
  logic [SUM_W-1:0]      quot;
  logic [CNT_W-1:0]      rem;
  logic [ITER_W-1:0]     iter;
  logic [ECHO_W-1:0]     mean;
  logic                  none_vld;
  logic [PROD_W-1:0]     prod;
  logic                  out_valid_q;
  out_item_t             out_item_q;

  // control
  logic                  in_acc;
  logic                  win_we;
  logic                  rd_en;
  logic                  out_load;
  logic [ECHO_W-1:0]     echo_clamped;
  logic                  hit;
  logic [CNT_W:0]        rem_sh;
  logic [CNT_W:0]        rem_diff;
  logic                  q_bit;
  logic [STEP_W-1:0]     step;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_q;
  assign out_item  = out_item_q;

  ersd_ram #(
    .WIDTH (ECHO_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (win_we),
    .waddr (write_slot),
    .wdata (echo_clamped),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !in_item.timed_out) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (rd_addr == LAST_ADDR) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:    state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (iter == '0) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:      state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_SWEEP: rd_en    = 1'b1;
      ST_DONE:  out_load = !out_valid_q || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_acc       = in_valid && in_ready;
  assign win_we       = in_acc && !in_item.timed_out;
  assign echo_clamped = (in_item.echo_us > max_echo) ? max_echo : in_item.echo_us;

  // an entry counts when written, nonzero and within the current limit
  assign hit = rd_pend && rd_vld && (rd_data != '0) && (rd_data <= max_echo);

  assign rem_sh   = {rem, quot[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, cnt};
  assign q_bit    = (rem_sh >= {1'b0, cnt});

  always_comb begin
    step = STEP_W'(1);
    for (int k = 1; k < STEP_CAP; k++) begin
      if (prod >= PROD_W'(k * STEP_DEN)) begin
        step = step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      max_echo    <= MAX_ECHO_RESET;
      write_slot  <= '0;
      entry_vld   <= '0;
      rd_pend     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (cfg_valid && cfg_ready) begin
        max_echo <= cfg_data;
      end
      if (win_we) begin
        entry_vld[write_slot] <= 1'b1;
        write_slot <= (write_slot == LAST_ADDR) ? '0 : write_slot + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_addr <= '0;
      sum     <= '0;
      cnt     <= '0;
    end else if (rd_en) begin
      rd_addr <= (rd_addr == LAST_ADDR) ? '0 : rd_addr + ADDR_W'(1);
    end
    rd_vld <= entry_vld[rd_addr];
    if (hit) begin
      sum <= sum + SUM_W'(rd_data);
      cnt <= cnt + CNT_W'(1);
    end
    if (state == ST_DIV_LOAD) begin
      quot <= sum;
      rem  <= '0;
      iter <= ITER_W'(SUM_W - 1);
    end else if (state == ST_DIV) begin
      quot <= {quot[SUM_W-2:0], q_bit};
      rem  <= q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      iter <= iter - ITER_W'(1);
    end
    if (state == ST_MUL) begin
      none_vld <= (cnt == '0);
      mean     <= (cnt == '0) ? '0 : quot[ECHO_W-1:0];
      prod     <= ((cnt == '0) ? '0 : PROD_W'(quot[ECHO_W-1:0])) * PROD_W'(SPEED_NUM);
    end
    if (out_load) begin
      out_item_q.mean_echo_us <= mean;
      out_item_q.none_valid   <= none_vld;
      out_item_q.range_step   <= step;
      out_item_q.duty_percent <= DUTY_W'(step * DUTY_W'(DUTY_SCALE));
    end
  end

endmodule

`default_nettype wire

>>> sv/ersd_checker.sv
// Port-level checks for the echo range filter, bound to the top level.
// Uses ersd_pkg for the item types and step constants.
`default_nettype none

module ersd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input ersd_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input ersd_pkg::out_item_t out_item
);

  import ersd_pkg::*;

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  a_step_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.range_step >= STEP_W'(1) &&
                  out_item.range_step <= STEP_W'(STEP_CAP) &&
                  out_item.duty_percent ==
                    DUTY_W'(out_item.range_step * DUTY_W'(DUTY_SCALE)))
    else $error("step out of range or duty not ten times step");

  a_empty_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.none_valid |->
      out_item.mean_echo_us == '0 && out_item.range_step == STEP_W'(1))
    else $error("empty window gave nonzero mean or step");

  // a counted item keeps the block busy for the sweep
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_item.timed_out |=> !in_ready)
    else $error("new item taken during window sweep");

endmodule

bind echo_range_filter_to_servo_duty ersd_checker u_ersd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

>>> tb/tb_echo_range_filter_to_servo_duty.sv
// Self-checking bench for echo_range_filter_to_servo_duty: drives echo items and
// limit writes, predicts the windowed mean, step and duty, and checks each result.
// Depends on ersd_pkg and the RTL top level only.

module tb_echo_range_filter_to_servo_duty;
  timeunit 1ns;
  timeprecision 1ps;

  import ersd_pkg::*;

  localparam int unsigned WINDOW_LEN    = 8;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned STALL_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int unsigned PHASE_ITEMS   = 242;

  typedef logic [ECHO_W-1:0] echo_t;

  // Windowed mean predictor plus queue of expected duty results.
  class echo_scoreboard;
    echo_t       limit_us;
    echo_t       window[WINDOW_LEN];
    int unsigned slot;
    out_item_t   duty_q[$];
    int unsigned errors;

    function new();
      limit_us = MAX_ECHO_RESET;
      foreach (window[i]) window[i] = '0;
      slot   = 0;
      errors = 0;
    endfunction

    function void set_limit(echo_t v);
      limit_us = v;
    endfunction

    function int unsigned pending();
      return duty_q.size();
    endfunction

    function void note_echo(in_item_t it);
      echo_t             e;
      longint unsigned   sum;
      int unsigned       cnt;
      longint unsigned   step;
      out_item_t         res;
      if (it.timed_out) return;
      e = (it.echo_us > limit_us) ? limit_us : it.echo_us;
      window[slot] = e;
      slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;
      sum = 0;
      cnt = 0;
      foreach (window[i]) begin
        if (window[i] != 0 && window[i] <= limit_us) begin
          sum += window[i];
          cnt++;
        end
      end
      res.mean_echo_us = (cnt != 0) ? echo_t'(sum / cnt) : '0;
      res.none_valid   = (cnt == 0);
      if (cnt == 0) begin
        step = 1;
      end else begin
        step = longint'(res.mean_echo_us) * SPEED_NUM / STEP_DEN + 1;
        if (step > STEP_CAP) step = STEP_CAP;
      end
      res.range_step   = STEP_W'(step);
      res.duty_percent = DUTY_W'(DUTY_SCALE * step);
      duty_q.push_back(res);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (duty_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got mean %0d flag %0d step %0d duty %0d",
                 $time, got.mean_echo_us, got.none_valid, got.range_step, got.duty_percent);
        return;
      end
      want = duty_q.pop_front();
      compare_field("mean_echo_us", want.mean_echo_us, got.mean_echo_us);
      compare_field("none_valid",   want.none_valid,   got.none_valid);
      compare_field("range_step",   want.range_step,   got.range_step);
      compare_field("duty_percent", want.duty_percent, got.duty_percent);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  echo_t     cfg_data;

  echo_scoreboard sb = new();
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    quiet_cycles;

  echo_range_filter_to_servo_duty #(
    .WINDOW_LEN(WINDOW_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_echo(input echo_t echo, input logic tmo);
    in_item_t it;
    it.echo_us   = echo;
    it.timed_out = tmo;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_echo(it);
  endtask

  // Limit changes only with the block drained and quiet.
  task automatic write_limit(input echo_t v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic echo_t pick_echo(input echo_t lim);
    echo_t e;
    case ($urandom_range(7))
      0:       e = $urandom_range(1) ? '0 : '1;
      1:       e = lim + echo_t'($urandom_range(2)) - 1'b1;  // straddle the limit
      2, 3:    e = echo_t'($urandom);
      default: e = echo_t'($urandom_range(lim));
    endcase
    return e;
  endfunction

  initial begin
    echo_t       lim;
    int unsigned sent;
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    quiet_cycles  = 0;
    send_idle_pct = 31;
    recv_idle_pct = 57;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset limit, empty window, zero echo, clamping, bit patterns
    send_echo(20'd1000, 1'b1);
    send_echo('0, 1'b0);
    send_echo(20'd1, 1'b0);
    send_echo(20'd20000, 1'b0);
    send_echo(20'd20001, 1'b0);
    send_echo('1, 1'b0);
    send_echo('1, 1'b1);
    send_echo(20'h55555, 1'b0);
    send_echo(20'hAAAAA, 1'b0);
    send_echo(20'd4834, 1'b0);
    send_echo(20'd4833, 1'b0);
    // full-scale window, then lower the limit so old entries drop out
    write_limit('1);
    repeat (WINDOW_LEN) send_echo('1, 1'b0);
    write_limit(20'd5000);
    send_echo(20'd100, 1'b0);
    // zero limit: everything clamps to zero, nothing valid
    write_limit('0);
    send_echo('1, 1'b0);
    send_echo('0, 1'b0);
    send_echo(20'd1, 1'b1);
    write_limit(20'd1);
    send_echo(20'd1, 1'b0);
    send_echo(20'd2, 1'b0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       lim = '1;
        1:       lim = MAX_ECHO_RESET;
        2:       lim = 20'd1;
        3:       lim = echo_t'($urandom);
        4:       lim = 20'd300000;
        default: lim = echo_t'($urandom_range(4000, 1));
      endcase
      write_limit(lim);
      case (p / 2)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          send_echo(echo_t'($urandom), 1'b1);
        end else begin
          send_echo(pick_echo(lim), 1'b0);
        end
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
